>>> rtl/slxfp_pkg.sv
// shared types and constants for the sync/length/xor frame parser
// no dependencies; imported by every module of the parser except the payload buffer
package slxfp_pkg;

   // word kinds on the request channel
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_CHECK = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   // parser phases
   localparam logic [2:0] PH_SYNC   = 3'd0;
   localparam logic [2:0] PH_CMD    = 3'd1;
   localparam logic [2:0] PH_LEN_LO = 3'd2;
   localparam logic [2:0] PH_LEN_HI = 3'd3;
   localparam logic [2:0] PH_DATA   = 3'd4;
   localparam logic [2:0] PH_SUM    = 3'd5;

   // result event codes
   localparam logic [2:0] EV_NONE     = 3'd0;
   localparam logic [2:0] EV_GOOD     = 3'd1;
   localparam logic [2:0] EV_BADSUM   = 3'd2;
   localparam logic [2:0] EV_OVERSIZE = 3'd3;
   localparam logic [2:0] EV_TIMEOUT  = 3'd4;

   // configuration register indexes
   localparam logic CSR_SYNC_VALUE = 1'b0;
   localparam logic CSR_TIMEOUT    = 1'b1;

   // register reset values
   localparam logic [7:0]  SYNC_RESET    = 8'h5A;
   localparam logic [15:0] TIMEOUT_RESET = 16'd200;

   // largest payload; sizes the buffer and bounds the read index and the length field
   localparam int MAX_PAYLOAD = 1024;

   // field widths
   localparam int CSR_W      = 16;
   localparam int LEN_W      = 16;
   localparam int LEN_HIGH_SHIFT = 8;
   localparam int CMP_W      = 17;
   localparam int OUT_LEN_W  = 11;
   localparam int IDX_W      = 10;

   // result fields produced by the parser control
   typedef struct packed {
      logic [2:0]           event_res;
      logic [7:0]           frame_command;
      logic [OUT_LEN_W-1:0] frame_length;
      logic [31:0]          bad_checksum_total;
      logic [31:0]          resync_total;
   } rsp_fields_type;

endpackage

>>> rtl/slxfp_buf.sv
// payload buffer: one write port, one registered read port
// no package dependencies
module slxfp_buf #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/slxfp_ctrl.sv
// parser control: phase machine, checksum, counters and config registers
// depends on slxfp_pkg
module slxfp_ctrl
   import slxfp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [1:0]        kind,
   input  logic [7:0]        data_byte,
   input  logic [31:0]       now_ms,
   input  logic              csr_wr_en,
   input  logic              csr_index,
   input  logic [CSR_W-1:0]  csr_wr_data,
   output rsp_fields_type    rsp_next,
   output logic              wr_en,
   output logic [IDX_W-1:0]  wr_addr,
   output logic [7:0]        wr_data
);

   localparam int POS_W = $clog2(MAX_PAYLOAD + 1);

   logic [7:0]       sync_value_ff;
   logic [15:0]      timeout_limit_ff;
   logic [2:0]       phase_ff, phase_in;
   logic [7:0]       command_ff, command_in;
   logic [LEN_W-1:0] length_ff, length_in;
   logic [POS_W-1:0] position_ff, position_in;
   logic [7:0]       xor_ff, xor_in;
   logic [31:0]      last_time_ff, last_time_in;
   logic [31:0]      bad_count_ff, bad_count_in;
   logic [31:0]      resync_count_ff, resync_count_in;

   logic [LEN_W-1:0] len_full;
   logic [31:0]      idle_time;

   assign len_full  = {data_byte, length_ff[LEN_HIGH_SHIFT-1:0]};
   assign idle_time = now_ms - last_time_ff;

   // next state and result for the word on the input
   always_comb begin
      phase_in        = phase_ff;
      command_in      = command_ff;
      length_in       = length_ff;
      position_in     = position_ff;
      xor_in          = xor_ff;
      last_time_in    = last_time_ff;
      bad_count_in    = bad_count_ff;
      resync_count_in = resync_count_ff;
      rsp_next.event_res     = EV_NONE;
      rsp_next.frame_command = 8'd0;
      rsp_next.frame_length  = '0;
      wr_en   = 1'b0;
      wr_addr = IDX_W'(position_ff);
      wr_data = data_byte;

      case (kind)
         KIND_BYTE: begin
            last_time_in = now_ms;
            case (phase_ff)
               PH_SYNC: begin
                  if (data_byte == sync_value_ff) begin
                     phase_in = PH_CMD;
                  end
               end
               PH_CMD: begin
                  command_in = data_byte;
                  xor_in     = data_byte;
                  phase_in   = PH_LEN_LO;
               end
               PH_LEN_LO: begin
                  length_in = LEN_W'(data_byte);
                  xor_in    = xor_ff ^ data_byte;
                  phase_in  = PH_LEN_HI;
               end
               PH_LEN_HI: begin
                  position_in = '0;
                  if (CMP_W'(len_full) > CMP_W'(MAX_PAYLOAD)) begin
                     // oversize length: count it and hunt for sync again
                     resync_count_in = resync_count_ff + 32'd1;
                     phase_in  = PH_SYNC;
                     length_in = '0;
                     xor_in    = 8'd0;
                     rsp_next.event_res = EV_OVERSIZE;
                  end else begin
                     length_in = len_full;
                     xor_in    = xor_ff ^ data_byte;
                     phase_in  = (len_full != '0) ? PH_DATA : PH_SUM;
                  end
               end
               PH_DATA: begin
                  wr_en       = accept &&
                                (CMP_W'(position_ff) < CMP_W'(MAX_PAYLOAD));
                  position_in = position_ff + POS_W'(1);
                  xor_in      = xor_ff ^ data_byte;
                  if (CMP_W'(position_ff) + CMP_W'(1) >= CMP_W'(length_ff)) begin
                     phase_in = PH_SUM;
                  end
               end
               PH_SUM: begin
                  if (data_byte != xor_ff) begin
                     bad_count_in = bad_count_ff + 32'd1;
                     rsp_next.event_res = EV_BADSUM;
                  end else begin
                     rsp_next.event_res     = EV_GOOD;
                     rsp_next.frame_command = command_ff;
                     rsp_next.frame_length  = OUT_LEN_W'(length_ff);
                  end
                  phase_in    = PH_SYNC;
                  length_in   = '0;
                  position_in = '0;
                  xor_in      = 8'd0;
               end
               default: begin
                  phase_in    = PH_SYNC;
                  length_in   = '0;
                  position_in = '0;
                  xor_in      = 8'd0;
               end
            endcase
         end
         KIND_CHECK: begin
            // abandon a frame that has gone quiet too long
            if ((phase_ff != PH_SYNC) && (idle_time >= 32'(timeout_limit_ff))) begin
               resync_count_in = resync_count_ff + 32'd1;
               phase_in    = PH_SYNC;
               length_in   = '0;
               position_in = '0;
               xor_in      = 8'd0;
               rsp_next.event_res = EV_TIMEOUT;
            end
         end
         default: begin
         end
      endcase

      rsp_next.bad_checksum_total = bad_count_in;
      rsp_next.resync_total       = resync_count_in;
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_SYNC;
         command_ff      <= 8'd0;
         length_ff       <= '0;
         position_ff     <= '0;
         xor_ff          <= 8'd0;
         last_time_ff    <= 32'd0;
         bad_count_ff    <= 32'd0;
         resync_count_ff <= 32'd0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         command_ff      <= command_in;
         length_ff       <= length_in;
         position_ff     <= position_in;
         xor_ff          <= xor_in;
         last_time_ff    <= last_time_in;
         bad_count_ff    <= bad_count_in;
         resync_count_ff <= resync_count_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_value_ff    <= SYNC_RESET;
         timeout_limit_ff <= TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SYNC_VALUE: sync_value_ff    <= csr_wr_data[7:0];
            CSR_TIMEOUT:    timeout_limit_ff <= csr_wr_data[15:0];
            default: begin
            end
         endcase
      end
   end

endmodule

>>> rtl/sync_length_xor_frame_parser_core.sv
// A result word appears in the cycle after its request word is taken.
// Throughput: one word per cycle unless a held result stalls the input; the
// single result register and one payload memory port per direction set it.
// Reset: synchronous, active high; clears parser state, counters, config
// registers and the result valid. The payload buffer is not cleared.
// depends on slxfp_pkg, slxfp_ctrl and slxfp_buf
module sync_length_xor_frame_parser_core
   import slxfp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_kind,
   input  logic [7:0]           req_data_byte,
   input  logic [31:0]          req_now_ms,
   input  logic [IDX_W-1:0]     req_read_index,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_event_res,
   output logic [7:0]           rsp_frame_command,
   output logic [OUT_LEN_W-1:0] rsp_frame_length,
   output logic [7:0]           rsp_read_data,
   output logic [31:0]          rsp_bad_checksum_total,
   output logic [31:0]          rsp_resync_total,
   input  logic                 csr_wr_en,
   input  logic                 csr_index,
   input  logic [CSR_W-1:0]     csr_wr_data
);

   logic           accept;
   rsp_fields_type rsp_next;
   rsp_fields_type rsp_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rd_hit_ff;
   logic           rd_en;
   logic [7:0]     rd_data;
   logic           wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [7:0]     wr_data;

   // handshake: take a word whenever the result register is free or draining
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // buffer read only for in-range read words
   assign rd_en = accept && (req_kind == KIND_READ) &&
                  (CMP_W'(req_read_index) < CMP_W'(MAX_PAYLOAD));

   slxfp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .kind        (req_kind),
      .data_byte   (req_data_byte),
      .now_ms      (req_now_ms),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .rsp_next    (rsp_next),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data)
   );

   slxfp_buf #(
      .DEPTH  (MAX_PAYLOAD),
      .ADDR_W (IDX_W)
   ) u_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (req_read_index),
      .rd_data (rd_data)
   );

   // result valid
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff    <= rsp_next;
         rd_hit_ff <= rd_en;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_event_res          = rsp_ff.event_res;
   assign rsp_frame_command      = rsp_ff.frame_command;
   assign rsp_frame_length       = rsp_ff.frame_length;
   assign rsp_read_data          = rd_hit_ff ? rd_data : 8'd0;
   assign rsp_bad_checksum_total = rsp_ff.bad_checksum_total;
   assign rsp_resync_total       = rsp_ff.resync_total;

endmodule

>>> rtl/slxfp_chk.sv
// port-level checks for the frame parser core, attached by bind
// depends on slxfp_pkg and sync_length_xor_frame_parser_core
module slxfp_chk
   import slxfp_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [2:0]           rsp_event_res,
   input logic [7:0]           rsp_frame_command,
   input logic [OUT_LEN_W-1:0] rsp_frame_length
);

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // an empty result register never holds back the input
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled while result register empty");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_res))
      else $error("stalled result changed");

   // event code stays within the defined set
   a_event_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_event_res <= EV_TIMEOUT))
      else $error("undefined event code");

   // frame fields are zero unless a good frame is reported
   a_frame_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res != EV_GOOD) |->
         (rsp_frame_command == 8'd0) && (rsp_frame_length == '0))
      else $error("frame fields set without a good frame");

endmodule

bind sync_length_xor_frame_parser_core slxfp_chk u_chk (.*);
